// ===== rtl/core/hsvpc_pkg.sv =====
package hsvpc_pkg;

	// Hue position: 3-bit sector over an 8-bit fraction, 0..1024
	localparam int HPOS_W = 11;
	localparam int FRAC_W = 8;
	localparam int SECT_W = HPOS_W - FRAC_W;
	localparam logic [HPOS_W-1:0] HPOS_FULL = HPOS_W'(1024);

	// Config bus
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		REG_MIN_VALUE  = 2'd0,
		REG_MAX_VALUE  = 2'd1,
		REG_SATURATION = 2'd2,
		REG_INTENSITY  = 2'd3
	} reg_idx_t;

	// 60-degree hue sectors, red at zero
	typedef enum logic [SECT_W-1:0] {
		SECT_RED_YEL = 3'd0,
		SECT_YEL_GRN = 3'd1,
		SECT_GRN_CYN = 3'd2,
		SECT_CYN_BLU = 3'd3,
		SECT_BLU_MAG = 3'd4
	} sector_t;

	// Hue word handed from the divider to the color stage
	typedef struct packed {
		logic              vld;
		logic [HPOS_W-1:0] hpos;
	} hue_t;

endpackage

// ===== rtl/core/hsvpc_hue.sv =====
// Clamp, then hue position = floor(1024 * (max - s) / (max - min)).
// One stage for the clamp, one restoring-division step per stage after it.
module hsvpc_hue #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_vld,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [SAMPLE_WIDTH-1:0] min_value,
	input  logic signed [SAMPLE_WIDTH-1:0] max_value,
	output hsvpc_pkg::hue_t                hue
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int STEPS = hsvpc_pkg::HPOS_W;

	logic signed [SW-1:0] clamped;
	logic signed [SW:0]   span_w;
	logic signed [SW:0]   num_w;
	logic                 empty_w;

	// Stage arrays, index 0 is the clamp stage
	logic [SW-1:0]                  rem_sd   [0:STEPS];
	logic [SW-1:0]                  span_sd  [0:STEPS];
	logic [hsvpc_pkg::HPOS_W-1:0]   quot_sd  [0:STEPS];
	logic                           empty_sd [0:STEPS];
	logic                           vld_sd   [0:STEPS];

	logic [SW:0]                    trial    [STEPS];
	logic [SW:0]                    diff     [STEPS];
	logic                           take     [STEPS];
	logic [SW-1:0]                  rem_nx   [STEPS];
	logic [hsvpc_pkg::HPOS_W-1:0]   quot_nx  [STEPS];

	// Clamp and distance from the top of the range
	always_comb begin
		if (sample < min_value) begin
			clamped = min_value;
		end else if (sample > max_value) begin
			clamped = max_value;
		end else begin
			clamped = sample;
		end
		span_w  = (SW+1)'(max_value) - (SW+1)'(min_value);
		num_w   = (SW+1)'(max_value) - (SW+1)'(clamped);
		empty_w = (max_value <= min_value);
	end

	// Division steps: the first yields the integer bit, the rest the fraction
	always_comb begin
		for (int k = 0; k < STEPS; k++) begin
			trial[k]   = (k == 0) ? {1'b0, rem_sd[k]} : {rem_sd[k], 1'b0};
			diff[k]    = trial[k] - {1'b0, span_sd[k]};
			take[k]    = (trial[k] >= {1'b0, span_sd[k]});
			rem_nx[k]  = take[k] ? diff[k][SW-1:0] : trial[k][SW-1:0];
			quot_nx[k] = {quot_sd[k][hsvpc_pkg::HPOS_W-2:0], take[k]};
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) begin
				vld_sd[k] <= 1'b0;
			end
		end else if (en) begin
			vld_sd[0] <= in_vld;
			for (int k = 0; k < STEPS; k++) begin
				vld_sd[k+1] <= vld_sd[k];
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0]   <= num_w[SW-1:0];
			span_sd[0]  <= span_w[SW-1:0];
			quot_sd[0]  <= '0;
			empty_sd[0] <= empty_w;
			for (int k = 0; k < STEPS; k++) begin
				rem_sd[k+1]   <= rem_nx[k];
				span_sd[k+1]  <= span_sd[k];
				quot_sd[k+1]  <= quot_nx[k];
				empty_sd[k+1] <= empty_sd[k];
			end
		end
	end

	// Empty or inverted span pins the hue to blue
	assign hue.vld  = vld_sd[STEPS];
	assign hue.hpos = empty_sd[STEPS] ? hsvpc_pkg::HPOS_FULL : quot_sd[STEPS];

endmodule

// ===== rtl/core/hsvpc_rgb.sv =====
// HSV to RGB: p, q, t products, a reciprocal step for the rounded division
// by 255*256, then the sector picks the channel order.
module hsvpc_rgb #(
	parameter int COLOR_WIDTH = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  hsvpc_pkg::hue_t        hue,
	input  logic [COLOR_WIDTH-1:0] saturation,
	input  logic [COLOR_WIDTH-1:0] intensity,
	output logic                   out_vld,
	output logic [COLOR_WIDTH-1:0] red,
	output logic [COLOR_WIDTH-1:0] green,
	output logic [COLOR_WIDTH-1:0] blue
);

	localparam int CW     = COLOR_WIDTH;
	localparam int FW     = hsvpc_pkg::FRAC_W;
	localparam int FACT_W = CW + FW;
	localparam int PROD_W = 2 * CW + FW;
	localparam int Y_W    = 2 * CW;
	localparam logic [CW-1:0]     CMAX = '1;
	localparam logic [FACT_W-1:0] BASE = {CMAX, {FW{1'b0}}};
	localparam logic [PROD_W-1:0] DEN  = PROD_W'(BASE);
	localparam logic [PROD_W-1:0] HALF = DEN >> 1;

	logic [FW-1:0]                frac;
	logic [FW:0]                  gfrac;
	logic [FACT_W-1:0]            sf_nx;
	logic [FACT_W-1:0]            sg_nx;

	logic                         vld_s1;
	logic [FACT_W-1:0]            sf_s1;
	logic [FACT_W-1:0]            sg_s1;
	logic [hsvpc_pkg::SECT_W-1:0] sect_s1;

	logic [FACT_W-1:0]            fact [3];

	// Lanes are p, q, t
	logic                         vld_s2;
	logic [PROD_W-1:0]            num_s2 [3];
	logic [hsvpc_pkg::SECT_W-1:0] sect_s2;

	logic [Y_W:0]                 recip [3];

	logic                         vld_s3;
	logic [CW-1:0]                quo_s3 [3];
	logic [hsvpc_pkg::SECT_W-1:0] sect_s3;

	logic [CW-1:0]                p_val;
	logic [CW-1:0]                q_val;
	logic [CW-1:0]                t_val;

	// Saturation times fraction and times its complement
	always_comb begin
		frac  = hue.hpos[FW-1:0];
		gfrac = (FW+1)'(1 << FW) - (FW+1)'(frac);
		sf_nx = FACT_W'(saturation) * FACT_W'(frac);
		sg_nx = FACT_W'(saturation) * FACT_W'(gfrac);
	end

	// Channel factors
	always_comb begin
		fact[0] = {CMAX - saturation, {FW{1'b0}}};
		fact[1] = BASE - sf_s1;
		fact[2] = BASE - sg_s1;
	end

	// Divide by CMAX*256: drop the low byte, then y / CMAX as
	// (y + (y >> CW) + 1) >> CW, exact while the quotient stays within CW bits
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			recip[l] = (Y_W+1)'(num_s2[l][PROD_W-1:FW])
				+ (Y_W+1)'(num_s2[l][PROD_W-1:FW+CW]) + (Y_W+1)'(1);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= hue.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			sf_s1   <= sf_nx;
			sg_s1   <= sg_nx;
			sect_s1 <= hue.hpos[hsvpc_pkg::HPOS_W-1:FW];
			sect_s2 <= sect_s1;
			sect_s3 <= sect_s2;
			for (int l = 0; l < 3; l++) begin
				num_s2[l] <= PROD_W'(intensity) * PROD_W'(fact[l]) + HALF;
				quo_s3[l] <= recip[l][Y_W-1:CW];
			end
		end
	end

	assign p_val   = quo_s3[0];
	assign q_val   = quo_s3[1];
	assign t_val   = quo_s3[2];
	assign out_vld = vld_s3;

	// Sector rules
	always_comb begin
		case (hsvpc_pkg::sector_t'(sect_s3))
			hsvpc_pkg::SECT_RED_YEL: begin
				red = intensity; green = t_val;     blue = p_val;
			end
			hsvpc_pkg::SECT_YEL_GRN: begin
				red = q_val;     green = intensity; blue = p_val;
			end
			hsvpc_pkg::SECT_GRN_CYN: begin
				red = p_val;     green = intensity; blue = t_val;
			end
			hsvpc_pkg::SECT_CYN_BLU: begin
				red = p_val;     green = q_val;     blue = intensity;
			end
			hsvpc_pkg::SECT_BLU_MAG: begin
				red = t_val;     green = p_val;     blue = intensity;
			end
			default: begin
				red = intensity; green = p_val;     blue = q_val;
			end
		endcase
	end

endmodule

// ===== rtl/core/value_to_hsv_pseudocolor.sv =====
// Heat-scale pseudocolor: each signed Q7.8 sample is clamped to
// [min_value, max_value], mapped to a hue from blue (min) to red (max) and
// turned into RGB with the programmed saturation and intensity. One word is
// accepted every clock while s_tready is high, and one word leaves for each;
// a result passes the clamp stage, eleven hue-division stages, two multiplier
// stages, one rounding stage and the output register. A two-entry output
// buffer absorbs back-pressure, so s_tready drops only when both entries are
// full. Program the registers only while the stream is idle.
module value_to_hsv_pseudocolor #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COLOR_WIDTH  = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Input stream
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_tdata,  // sample_value
	// Output stream
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [((3*COLOR_WIDTH+7)/8)*8-1:0]       m_tdata,  // red, green, blue
	// Register port
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [hsvpc_pkg::ADDR_W-1:0]             paddr,
	input  logic [hsvpc_pkg::DATA_W-1:0]             pwdata,
	output logic [hsvpc_pkg::DATA_W-1:0]             prdata,
	output logic                                     pready
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int CW    = COLOR_WIDTH;
	localparam int OUT_W = ((3 * CW + 7) / 8) * 8;

	logic signed [SW-1:0] min_q;
	logic signed [SW-1:0] max_q;
	logic [CW-1:0]        sat_q;
	logic [CW-1:0]        int_q;

	logic                 wr_en;
	hsvpc_pkg::reg_idx_t  reg_idx;

	logic                 en;
	hsvpc_pkg::hue_t      hue;
	logic                 res_vld;
	logic [CW-1:0]        res_red;
	logic [CW-1:0]        res_green;
	logic [CW-1:0]        res_blue;
	logic [3*CW-1:0]      res_word;

	logic                 out_v_q;
	logic [3*CW-1:0]      out_q;
	logic                 skid_v_q;
	logic [3*CW-1:0]      skid_q;
	logic                 pop;
	logic                 push;

	// Register port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = hsvpc_pkg::reg_idx_t'(paddr[hsvpc_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= SW'(0);
			max_q <= SW'(256);
			sat_q <= '1;
			int_q <= '1;
		end else if (wr_en) begin
			unique case (reg_idx)
				hsvpc_pkg::REG_MIN_VALUE:  min_q <= pwdata[SW-1:0];
				hsvpc_pkg::REG_MAX_VALUE:  max_q <= pwdata[SW-1:0];
				hsvpc_pkg::REG_SATURATION: sat_q <= pwdata[CW-1:0];
				hsvpc_pkg::REG_INTENSITY:  int_q <= pwdata[CW-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hsvpc_pkg::REG_MIN_VALUE:  prdata = hsvpc_pkg::DATA_W'(min_q);
			hsvpc_pkg::REG_MAX_VALUE:  prdata = hsvpc_pkg::DATA_W'(max_q);
			hsvpc_pkg::REG_SATURATION: prdata = hsvpc_pkg::DATA_W'(sat_q);
			hsvpc_pkg::REG_INTENSITY:  prdata = hsvpc_pkg::DATA_W'(int_q);
		endcase
	end

	// Whole pipeline moves while the skid entry is free
	assign en       = !skid_v_q;
	assign s_tready = en;

	hsvpc_hue #(
		.SAMPLE_WIDTH(SW)
	) u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (s_tvalid),
		.sample    (s_tdata[SW-1:0]),
		.min_value (min_q),
		.max_value (max_q),
		.hue       (hue)
	);

	hsvpc_rgb #(
		.COLOR_WIDTH(CW)
	) u_rgb (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.hue        (hue),
		.saturation (sat_q),
		.intensity  (int_q),
		.out_vld    (res_vld),
		.red        (res_red),
		.green      (res_green),
		.blue       (res_blue)
	);

	// Output register with one skid entry
	assign res_word = {res_blue, res_green, res_red};
	assign pop      = out_v_q && m_tready;
	assign push     = res_vld && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_q <= res_word;
			end else begin
				out_q <= res_word;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_W'(out_q);

endmodule

// ===== test/value_to_hsv_pseudocolor_tb.sv =====
`timescale 1ns / 1ps

module value_to_hsv_pseudocolor_tb;

	localparam int SAMPLE_W     = 16;
	localparam int COLOR_W      = 8;
	localparam int PIPE_LATENCY = 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int CHAN_DEN     = 255 * 256;
	localparam int RESET_CYCLES = 9;

	// red in the low byte, as on m_tdata
	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} rgb_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [15:0]                    s_tdata;   // sample_value
	logic                           m_tvalid;
	logic                           m_tready;
	logic [23:0]                    m_tdata;   // red, green, blue
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [hsvpc_pkg::ADDR_W-1:0]   paddr;
	logic [hsvpc_pkg::DATA_W-1:0]   pwdata;
	logic [hsvpc_pkg::DATA_W-1:0]   prdata;
	logic                           pready;

	// Shadow copy of the programmed registers
	logic signed [SAMPLE_W-1:0] cfg_min = 16'sd0;
	logic signed [SAMPLE_W-1:0] cfg_max = 16'sd256;
	logic [COLOR_W-1:0]         cfg_sat = 8'd255;
	logic [COLOR_W-1:0]         cfg_int = 8'd255;

	rgb_t expected_colors[$];
	rgb_t want_color;
	rgb_t got_color;

	int fail_count       = 0;
	int words_sent       = 0;
	int colors_checked   = 0;
	int settings_applied = 0;
	int cycle_count      = 0;
	int send_idle_pct    = 0;
	int recv_idle_pct    = 0;
	int hold_off_cycles  = 0;

	value_to_hsv_pseudocolor u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("** value_to_hsv_pseudocolor: FAILED **");
			$finish;
		end
	end

	// Channel scaling: v * factor / (255*256), rounded half up
	function automatic logic [COLOR_W-1:0] scale_chan(logic [COLOR_W-1:0] v, int factor);
		return COLOR_W'((int'(v) * factor + CHAN_DEN / 2) / CHAN_DEN);
	endfunction

	// Expected color for one sample under the current register settings
	function automatic rgb_t heat_color(logic signed [SAMPLE_W-1:0] sample);
		int span;
		int clamped;
		int hpos;
		int frac;
		int sat;
		logic [COLOR_W-1:0] v;
		logic [COLOR_W-1:0] p;
		logic [COLOR_W-1:0] q;
		logic [COLOR_W-1:0] t;
		hsvpc_pkg::sector_t sect;
		rgb_t c;
		span = int'(cfg_max) - int'(cfg_min);
		if (span <= 0) begin
			hpos = 1024;
		end else begin
			clamped = int'(sample);
			if (clamped < int'(cfg_min)) clamped = int'(cfg_min);
			if (clamped > int'(cfg_max)) clamped = int'(cfg_max);
			hpos = ((span - (clamped - int'(cfg_min))) * 1024) / span;
		end
		sect = hsvpc_pkg::sector_t'(hpos >> hsvpc_pkg::FRAC_W);
		frac = hpos & 255;
		sat  = int'(cfg_sat);
		v    = cfg_int;
		if (sat == 0) begin
			c.red = v; c.green = v; c.blue = v;
			return c;
		end
		p = scale_chan(v, (255 - sat) * 256);
		q = scale_chan(v, CHAN_DEN - sat * frac);
		t = scale_chan(v, CHAN_DEN - sat * (256 - frac));
		case (sect)
			hsvpc_pkg::SECT_RED_YEL: begin c.red = v; c.green = t; c.blue = p; end
			hsvpc_pkg::SECT_YEL_GRN: begin c.red = q; c.green = v; c.blue = p; end
			hsvpc_pkg::SECT_GRN_CYN: begin c.red = p; c.green = v; c.blue = t; end
			hsvpc_pkg::SECT_CYN_BLU: begin c.red = p; c.green = q; c.blue = v; end
			hsvpc_pkg::SECT_BLU_MAG: begin c.red = t; c.green = p; c.blue = v; end
			default: begin c.red = v; c.green = p; c.blue = q; end
		endcase
		return c;
	endfunction

	// Receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Result check against the oldest expected color
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_color = m_tdata;
			if (expected_colors.size() == 0) begin
				$display("%0t: unexpected word, actual %h", $time, got_color);
				fail_count++;
			end else begin
				want_color = expected_colors.pop_front();
				colors_checked++;
				if (got_color.red !== want_color.red) begin
					$display("%0t: red mismatch, expected %0d actual %0d",
						$time, want_color.red, got_color.red);
					fail_count++;
				end
				if (got_color.green !== want_color.green) begin
					$display("%0t: green mismatch, expected %0d actual %0d",
						$time, want_color.green, got_color.green);
					fail_count++;
				end
				if (got_color.blue !== want_color.blue) begin
					$display("%0t: blue mismatch, expected %0d actual %0d",
						$time, want_color.blue, got_color.blue);
					fail_count++;
				end
			end
		end
	end

	// Offer one sample word, with an optional gap first
	task automatic send_word(input logic [SAMPLE_W-1:0] sample);
		int gap;
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sample;
		do @(posedge clk); while (!s_tready);
		expected_colors.push_back(heat_color(sample));
		words_sent++;
	endtask

	// Stop offering and wait until every expected color has arrived
	task automatic drain_stream();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_colors.size() != 0) @(posedge clk);
	endtask

	task automatic reg_write(input hsvpc_pkg::reg_idx_t idx,
		input logic [hsvpc_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			hsvpc_pkg::REG_MIN_VALUE:  cfg_min = value[SAMPLE_W-1:0];
			hsvpc_pkg::REG_MAX_VALUE:  cfg_max = value[SAMPLE_W-1:0];
			hsvpc_pkg::REG_SATURATION: cfg_sat = value[COLOR_W-1:0];
			hsvpc_pkg::REG_INTENSITY:  cfg_int = value[COLOR_W-1:0];
			default: ;
		endcase
	endtask

	// Program all four registers once the stream is idle
	task automatic apply_setting(input int min_v, input int max_v, input int sat, input int inten);
		drain_stream();
		reg_write(hsvpc_pkg::REG_MIN_VALUE, hsvpc_pkg::DATA_W'(min_v));
		reg_write(hsvpc_pkg::REG_MAX_VALUE, hsvpc_pkg::DATA_W'(max_v));
		reg_write(hsvpc_pkg::REG_SATURATION, hsvpc_pkg::DATA_W'(sat));
		reg_write(hsvpc_pkg::REG_INTENSITY, hsvpc_pkg::DATA_W'(inten));
		settings_applied++;
	endtask

	function automatic int pick_level();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return 0;
		if (sel == 1) return 255;
		return $urandom_range(0, 255);
	endfunction

	task automatic apply_random_setting();
		int mode;
		int a;
		int b;
		mode = $urandom_range(0, 9);
		a = int'($urandom_range(0, 65535)) - 32768;
		b = int'($urandom_range(0, 65535)) - 32768;
		case (mode)
			0: begin a = -32768; b = 32767; end
			1: b = a;
			2: if (a < b) begin mode = a; a = b; b = mode; end
			3, 4, 5: begin
				// narrow span
				if (a > 32767 - 1024) a = 32767 - 1024;
				b = a + $urandom_range(1, 1024);
			end
			default: if (a > b) begin mode = a; a = b; b = mode; end
		endcase
		apply_setting(a, b, pick_level(), pick_level());
	endtask

	// Mostly samples inside the span, the rest anywhere
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int sel;
		int span;
		sel  = $urandom_range(0, 9);
		span = int'(cfg_max) - int'(cfg_min);
		if (sel == 0) return cfg_min;
		if (sel == 1) return cfg_max;
		if (sel < 6 && span > 0) return SAMPLE_W'(int'(cfg_min) + int'($urandom_range(0, span)));
		return SAMPLE_W'($urandom_range(0, 65535));
	endfunction

	// Reset settings: span 0..256 walks through every sector
	task automatic test_reset_defaults();
		logic [SAMPLE_W-1:0] samples[$];
		samples = '{16'h8000, 16'h7fff, 16'd0, 16'd256, 16'd16, 16'd80,
			16'd144, 16'd208, 16'd255, 16'd1, 16'd128};
		foreach (samples[i]) send_word(samples[i]);
	endtask

	task automatic test_special_cases();
		// empty span
		apply_setting(100, 100, 255, 255);
		send_word(16'd100);
		send_word(16'hfffb);
		// inverted span
		apply_setting(300, -300, 255, 255);
		send_word(16'd0);
		send_word(16'h8000);
		// zero saturation gives grey
		apply_setting(-32768, 32767, 0, 200);
		send_word(16'd0);
		send_word(16'd12345);
		// zero intensity
		apply_setting(-32768, 32767, 255, 0);
		send_word(16'h8000);
		send_word(16'h7fff);
		send_word(16'd0);
		// full span, half saturation
		apply_setting(-32768, 32767, 128, 255);
		send_word(16'h8000);
		send_word(16'h7fff);
		send_word(16'h0000);
		send_word(16'h4000);
	endtask

	task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int n_words);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		repeat (4) begin
			apply_random_setting();
			repeat (n_words / 4) send_word(pick_sample());
		end
	endtask

	// Long receiver hold-off while the sender keeps offering
	task automatic test_output_stall();
		apply_setting(-1000, 1000, 200, 230);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_off_cycles = 300;
		repeat (80) send_word(pick_sample());
		drain_stream();
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_special_cases();
		test_random_phase(31, 71, 400);
		test_random_phase(71, 31, 400);
		test_random_phase(0, 0, 400);
		test_output_stall();

		drain_stream();
		repeat (PIPE_LATENCY * 2) @(posedge clk);

		$display("Sent %0d sample words over %0d register settings; %0d colors checked,",
			words_sent, settings_applied, colors_checked);
		$display("including span extremes, grey, black and a long output stall.");
		if (fail_count == 0) begin
			$display("** value_to_hsv_pseudocolor: PASSED **");
		end else begin
			$display("** value_to_hsv_pseudocolor: FAILED **");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hsvpc_pkg.sv
rtl/core/hsvpc_hue.sv
rtl/core/hsvpc_rgb.sv
rtl/core/value_to_hsv_pseudocolor.sv
test/value_to_hsv_pseudocolor_tb.sv
